// File: src/cfrx_pkg.sv
// Shared types, constants and the CRC-16 byte update for the command frame receiver.
package cfrx_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0] ESCAPE_RESET = 8'd47;
	localparam int TDATA_W = 56;

	// Register indexes on the configuration port.
	localparam logic REG_ESCAPE = 1'b0;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_CMD,
		PH_ADDR_HI,
		PH_ADDR_LO,
		PH_LEN,
		PH_PARAM,
		PH_CRC_HI,
		PH_CRC_LO
	} phase_t;

	typedef struct packed {
		logic        is_frame_end;
		logic [7:0]  command;
		logic [15:0] address;
		logic [8:0]  param_count;
		logic [7:0]  param_index;
		logic [7:0]  param_byte;
		logic        crc_ok;
	} result_t;

	// CRC-16 XMODEM update for one byte, MSB first.
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: src/cfrx_regs.sv
// Configuration register file: the escape byte behind an APB-style port.
module cfrx_regs
	import cfrx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  escape_byte
);

	logic [7:0] escape_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= ESCAPE_RESET;
		end else if (wr_en && paddr[2] == REG_ESCAPE) begin
			escape_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_ESCAPE) begin
			prdata = {24'd0, escape_q};
		end
	end

	assign escape_byte = escape_q;

endmodule

// File: src/cfrx_deframer.sv
// Input register, frame state machine and running CRC of the command frame receiver.
module cfrx_deframer
	import cfrx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] escape_byte,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       res_valid,
	output result_t    res
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire;

	phase_t      phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] addr_q, addr_d;
	logic [8:0]  count_q, count_d;
	logic [8:0]  rcvd_q, rcvd_d;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic [15:0] crc_upd;
	logic [8:0]  rcvd_inc;

	assign fire = valid_s1 & advance;
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			crc_q    <= 16'd0;
			cmd_q    <= 8'd0;
			addr_q   <= 16'd0;
			count_q  <= 9'd0;
			rcvd_q   <= 9'd0;
			crc_hi_q <= 8'd0;
		end else if (fire) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			cmd_q    <= cmd_d;
			addr_q   <= addr_d;
			count_q  <= count_d;
			rcvd_q   <= rcvd_d;
			crc_hi_q <= crc_hi_d;
		end
	end

	assign crc_upd  = crc_step((phase_q == PH_HUNT) ? 16'd0 : crc_q, byte_s1);
	assign rcvd_inc = rcvd_q + 9'd1;

	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		cmd_d     = cmd_q;
		addr_d    = addr_q;
		count_d   = count_q;
		rcvd_d    = rcvd_q;
		crc_hi_d  = crc_hi_q;
		res_valid = 1'b0;
		res.is_frame_end = 1'b0;
		res.command      = cmd_q;
		res.address      = addr_q;
		res.param_count  = count_q;
		res.param_index  = 8'd0;
		res.param_byte   = 8'd0;
		res.crc_ok       = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				crc_d = crc_upd;
				if (byte_s1 == escape_byte) begin
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				crc_d   = crc_upd;
				cmd_d   = byte_s1;
				phase_d = PH_ADDR_HI;
			end
			PH_ADDR_HI: begin
				crc_d   = crc_upd;
				addr_d  = {byte_s1, 8'd0};
				phase_d = PH_ADDR_LO;
			end
			PH_ADDR_LO: begin
				crc_d   = crc_upd;
				addr_d  = {addr_q[15:8], byte_s1};
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				crc_d   = crc_upd;
				count_d = (byte_s1 == 8'd0) ? 9'd256 : {1'b0, byte_s1};
				rcvd_d  = 9'd0;
				phase_d = PH_PARAM;
			end
			PH_PARAM: begin
				crc_d            = crc_upd;
				res_valid        = valid_s1;
				res.param_index  = rcvd_q[7:0];
				res.param_byte   = byte_s1;
				rcvd_d           = rcvd_inc;
				if (rcvd_inc >= count_q) begin
					phase_d = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				crc_hi_d = byte_s1;
				phase_d  = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				res_valid        = valid_s1;
				res.is_frame_end = 1'b1;
				res.crc_ok       = ({crc_hi_q, byte_s1} == crc_q);
				phase_d          = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

endmodule

// File: src/cfrx_out_reg.sv
// Output register that holds one result word and packs it onto the master stream.
module cfrx_out_reg
	import cfrx_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance_en,
	input  logic               res_valid,
	input  result_t            res,
	output logic               advance,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tlast
);

	logic    valid_q;
	result_t res_q;

	assign advance = ~valid_q | m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= advance_en & res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && advance_en && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast  = res_q.is_frame_end;
	assign m_axis_tdata  = {6'd0, res_q.crc_ok, res_q.param_byte, res_q.param_index,
		res_q.param_count, res_q.address, res_q.command};

endmodule

// File: src/crc_checked_command_frame_receiver.sv
// Top level of the CRC-16 checked command frame receiver.
//
//   Channel   Direction  Words                          Handshake
//   s_axis    in         one received byte              tvalid/tready
//   m_axis    out        parameter byte or frame summary tvalid/tready, tlast = frame end
//   APB       in         escape byte register at 0x0    psel/penable/pwrite, pready high
//
// Each byte is held in the input register and then moves to the output register, which
// offers any result word on the master stream. One byte is taken every cycle while the
// master stream takes words; the frame state, CRC and header registers update as the
// byte leaves the input register. A stalled master stream holds the output word and stops
// the input register, and tready on the slave side falls only when both registers are full
// and the master stream holds off. Reset clears the frame state to hunting with a zero CRC
// and sets the escape byte to 47.
module crc_checked_command_frame_receiver
	import cfrx_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Slave stream: tdata[7:0] = rx_byte.
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,
	// Master stream: tdata[7:0] command, [23:8] address, [32:24] param_count,
	// [40:33] param_index, [48:41] param_byte, [49] crc_ok, [55:50] zero.
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tlast,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [7:0] escape_byte;
	logic       advance;
	logic       res_valid;
	result_t    res;

	cfrx_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.escape_byte (escape_byte)
	);

	// The deframer walks the frame phases and keeps the running CRC.
	cfrx_deframer u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.escape_byte (escape_byte),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.advance     (advance),
		.res_valid   (res_valid),
		.res         (res)
	);

	// The output register holds a word while it waits downstream and stops the input register until it is taken.
	cfrx_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance_en    (1'b1),
		.res_valid     (res_valid),
		.res           (res),
		.advance       (advance),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: tb/crc_checked_command_frame_receiver_test.sv
// Testbench for the CRC-16 checked command frame receiver: directed frames, config and random traffic.
module crc_checked_command_frame_receiver_test;
	import cfrx_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Byte addresses on the configuration port. Index 1 holds no register, so a
	// write there must leave the escape byte alone.
	localparam logic [2:0] ADDR_ESCAPE = {REG_ESCAPE, 2'b00};
	localparam logic [2:0] ADDR_UNUSED = 3'd4;

	// The watchdog ends the run once the count of cycles in which no word moves on
	// either stream and the configuration port is quiet reaches this limit. The longest
	// correct gap is the deliberate receiver hold-off.
	localparam int STALL_LIMIT = 2000;

	// Cycles allowed after the last expected word for bytes that cause no word
	// (header and CRC bytes) to clear the block's two pipeline registers.
	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;	// [7:0] rx_byte

	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;	// [7:0] command, [23:8] address, [32:24] param_count,
						// [40:33] param_index, [48:41] param_byte, [49] crc_ok
	logic m_axis_tlast;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;

	crc_checked_command_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// Words the block owes us, oldest first.
	result_t expected_results[$];
	int mismatches = 0;
	int stall_cycles = 0;

	// Stimulus-side bookkeeping: the escape byte the host believes is active,
	// the CRC of the frame being built, and how many bytes have been accepted.
	logic [7:0] escape_now = ESCAPE_RESET;
	logic [15:0] tx_crc = 16'h0000;
	int sent_count = 0;

	// When set, neither side idles; used to make back-to-back stretches.
	bit steady = 1'b0;
	// A nonzero value asks the receiver to hold tready low for that many cycles.
	int hold_request = 0;

	// Predictor state, a private copy of the deframer's registers.
	logic [7:0] model_escape = ESCAPE_RESET;
	phase_t model_phase = PH_HUNT;
	logic [15:0] model_crc = 16'h0000;
	logic [7:0] model_command = 8'h00;
	logic [15:0] model_address = 16'h0000;
	logic [8:0] model_count = 9'd0;
	logic [8:0] model_received = 9'd0;
	logic [7:0] model_crc_high = 8'h00;

	// CRC-16 XMODEM, one message bit at a time, MSB first.
	function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] crc,
		input logic [7:0] data);
		logic [15:0] c;
		logic feedback;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			feedback = c[15] ^ data[i];
			c = {c[14:0], 1'b0};
			if (feedback) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// Predictor and checker share one process so that a word predicted and a word
	// delivered at the same edge are always handled in a fixed order. Everything is
	// sampled at the rising edge, before the block's own updates land.
	always @(posedge clk) begin : frame_model
		result_t want;
		result_t got;
		logic [7:0] rx;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == ADDR_ESCAPE) begin
				model_escape = pwdata[7:0];
			end

			if (s_axis_tvalid && s_axis_tready) begin
				rx = s_axis_tdata;
				// Header fields are stable in the phases that emit a word.
				want = '0;
				want.command = model_command;
				want.address = model_address;
				want.param_count = model_count;
				case (model_phase)
				PH_HUNT: begin
					// Every byte examined while hunting restarts the CRC.
					model_crc = crc16_xmodem_byte(16'h0000, rx);
					if (rx == model_escape) begin
						model_phase = PH_CMD;
					end
				end
				PH_CMD: begin
					model_crc = crc16_xmodem_byte(model_crc, rx);
					model_command = rx;
					model_phase = PH_ADDR_HI;
				end
				PH_ADDR_HI: begin
					model_crc = crc16_xmodem_byte(model_crc, rx);
					model_address = {rx, 8'h00};
					model_phase = PH_ADDR_LO;
				end
				PH_ADDR_LO: begin
					model_crc = crc16_xmodem_byte(model_crc, rx);
					model_address[7:0] = rx;
					model_phase = PH_LEN;
				end
				PH_LEN: begin
					// A length byte of zero announces 256 parameter bytes.
					model_crc = crc16_xmodem_byte(model_crc, rx);
					model_count = (rx == 8'h00) ? 9'd256 : {1'b0, rx};
					model_received = 9'd0;
					model_phase = PH_PARAM;
				end
				PH_PARAM: begin
					// Parameter bytes are data even when they equal the escape byte.
					model_crc = crc16_xmodem_byte(model_crc, rx);
					want.param_index = model_received[7:0];
					want.param_byte = rx;
					expected_results.push_back(want);
					model_received = model_received + 9'd1;
					if (model_received >= model_count) begin
						model_phase = PH_CRC_HI;
					end
				end
				PH_CRC_HI: begin
					// The CRC bytes themselves stay out of the running CRC.
					model_crc_high = rx;
					model_phase = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					// Summary word: index and byte read as zero.
					want.is_frame_end = 1'b1;
					want.crc_ok = ({model_crc_high, rx} == model_crc);
					expected_results.push_back(want);
					model_phase = PH_HUNT;
				end
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got.is_frame_end = m_axis_tlast;
				got.command = m_axis_tdata[7:0];
				got.address = m_axis_tdata[23:8];
				got.param_count = m_axis_tdata[32:24];
				got.param_index = m_axis_tdata[40:33];
				got.param_byte = m_axis_tdata[48:41];
				got.crc_ok = m_axis_tdata[49];
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf(
						"unexpected word: end=%0d cmd=%02h addr=%04h count=%0d idx=%0d byte=%02h ok=%0d",
						got.is_frame_end, got.command, got.address, got.param_count,
						got.param_index, got.param_byte, got.crc_ok));
				end else begin
					want = expected_results.pop_front();
					if (got.is_frame_end !== want.is_frame_end || got.command !== want.command ||
							got.address !== want.address ||
							got.param_count !== want.param_count ||
							got.param_index !== want.param_index ||
							got.param_byte !== want.param_byte || got.crc_ok !== want.crc_ok) begin
						note_mismatch($sformatf({
							"word differs: expected end=%0d cmd=%02h addr=%04h count=%0d ",
							"idx=%0d byte=%02h ok=%0d, got end=%0d cmd=%02h addr=%04h ",
							"count=%0d idx=%0d byte=%02h ok=%0d"},
							want.is_frame_end, want.command, want.address, want.param_count,
							want.param_index, want.param_byte, want.crc_ok,
							got.is_frame_end, got.command, got.address, got.param_count,
							got.param_index, got.param_byte, got.crc_ok));
					end
				end
			end
		end
	end

	// Watchdog: a run that stops moving words is a failure.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("crc_checked_command_frame_receiver: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Receiver: before each word it stalls at random unless steady is set, and when a
	// long hold-off has been requested it first keeps tready low for the
	// requested count so that both of the block's registers fill up.
	initial begin : word_receiver
		int gap;
		int held;
		forever begin
			if (hold_request != 0) begin
				held = hold_request;
				hold_request = 0;
				m_axis_tready <= 1'b0;
				repeat (held) @(posedge clk);
			end
			gap = steady ? 0 : $urandom_range(0, 3);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid && hold_request == 0);
		end
	end

	// Offers one byte, after random idle time unless steady is set, and returns at the edge
	// where it is accepted. tvalid is left high so that the next byte can follow at once.
	task automatic send_byte(input logic [7:0] data);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		do @(posedge clk); while (!s_axis_tready);
		tx_crc = crc16_xmodem_byte(tx_crc, data);
		sent_count++;
	endtask

	// Stops offering bytes, waits for every owed word and lets the pipeline settle.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB transfer: setup phase, access phase, then a quiet idle phase.
	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writes the escape byte and reads it back. Callers make sure the block is idle.
	task automatic set_escape(input logic [7:0] value);
		logic [31:0] rdata;
		apb_access(1'b1, ADDR_ESCAPE, {24'h0, value}, rdata);
		escape_now = value;
		apb_access(1'b0, ADDR_ESCAPE, 32'h0, rdata);
		if (rdata !== {24'h0, escape_now}) begin
			note_mismatch($sformatf("escape byte read back %08h, expected %02h", rdata,
				escape_now));
		end
	endtask

	// Sends a whole frame with the current escape byte. A bad CRC flips one bit of
	// the check value; escape_fill makes every parameter byte equal the escape byte.
	task automatic send_frame(input logic [7:0] command, input logic [15:0] address,
		input logic [7:0] length, input bit bad_crc, input bit escape_fill);
		int count;
		logic [15:0] check;
		count = (length == 8'h00) ? 256 : length;
		tx_crc = 16'h0000;
		send_byte(escape_now);
		send_byte(command);
		send_byte(address[15:8]);
		send_byte(address[7:0]);
		send_byte(length);
		for (int i = 0; i < count; i++) begin
			send_byte(escape_fill ? escape_now : 8'($urandom));
		end
		check = tx_crc;
		if (bad_crc) begin
			check = check ^ (16'h0001 << $urandom_range(0, 15));
		end
		send_byte(check[15:8]);
		send_byte(check[7:0]);
	endtask

	// Reset escape byte: bytes other than the escape are skipped, header extremes
	// pass through, the escape value inside a frame is plain data, and a bad CRC
	// is flagged.
	task automatic test_default_escape();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(8'hFF, 16'hFFFF, 8'd1, 1'b0, 1'b0);
		send_frame(8'h00, 16'h0000, 8'd2, 1'b1, 1'b1);
	endtask

	// Escape byte register: both extremes, a write to an address with no register,
	// and a change of escape byte in the middle of a frame, which must only take
	// effect once the block hunts again.
	task automatic test_escape_register();
		logic [31:0] rdata;
		logic [15:0] check;
		wait_drained();
		set_escape(8'h00);
		apb_access(1'b1, ADDR_UNUSED, 32'hFFFF_FFFF, rdata);
		send_byte(8'hFF);
		send_frame(8'h5A, 16'h8001, 8'd1, 1'b0, 1'b0);
		wait_drained();
		set_escape(8'hFF);
		send_byte(8'h00);
		send_frame(8'hA5, 16'h7FFE, 8'd1, 1'b0, 1'b0);

		tx_crc = 16'h0000;
		send_byte(escape_now);
		send_byte(8'h3C);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'd3);
		// Only header bytes are in flight, so no word is owed; the settle time
		// covers the bytes still inside the block.
		wait_drained();
		set_escape(8'h5A);
		send_byte(8'h5A);
		send_byte(8'hFF);
		send_byte(8'h00);
		check = tx_crc;
		send_byte(check[15:8]);
		send_byte(check[7:0]);
		// The old escape byte no longer opens a frame.
		send_byte(8'hFF);
		send_frame(8'h81, 16'h0100, 8'd2, 1'b0, 1'b0);
	endtask

	// The receiver holds off for a long stretch while bytes keep coming, so the
	// block fills and drops tready; afterwards the sender waits for every word.
	task automatic test_output_backpressure();
		steady = 1'b1;
		hold_request = 48;
		send_frame(8'($urandom), 16'($urandom), 8'd30, 1'b0, 1'b0);
		steady = 1'b0;
		wait_drained();
	endtask

	// A length byte of zero: 256 parameter bytes, indexes running from 0 to 255.
	task automatic test_longest_frame();
		send_frame(8'($urandom), 16'($urandom), 8'h00, 1'b0, 1'b0);
	endtask

	// Mostly well-formed frames with random content and short lengths, mixed with
	// line noise, corrupted CRCs and frames cut short after the header. The escape
	// byte changes between phases and ends at its reset value.
	task automatic test_random_traffic();
		int target;
		int pick;
		int length;
		logic [7:0] noise;
		for (int round = 0; round < 3; round++) begin
			target = sent_count + 20;
			while (sent_count < target) begin
				steady = ($urandom_range(0, 4) == 0);
				repeat ($urandom_range(0, 3)) begin
					do noise = 8'($urandom); while (noise == escape_now);
					send_byte(noise);
				end
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					// Truncated frame: the next bytes on the line become its payload.
					send_byte(escape_now);
					send_byte(8'($urandom));
					send_byte(8'($urandom));
					send_byte(8'($urandom));
					send_byte(8'($urandom_range(1, 4)));
				end else begin
					if (pick < 70) begin
						length = $urandom_range(1, 6);
					end else if (pick < 95) begin
						length = $urandom_range(7, 24);
					end else begin
						length = $urandom_range(25, 64);
					end
					send_frame(8'($urandom), 16'($urandom), 8'(length),
						$urandom_range(0, 4) == 0, $urandom_range(0, 19) == 0);
				end
			end
			steady = 1'b0;
			wait_drained();
			set_escape(round == 2 ? ESCAPE_RESET : 8'($urandom));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_escape();
		test_escape_register();
		test_output_backpressure();
		test_longest_frame();
		test_random_traffic();
		wait_drained();
		if (mismatches == 0) begin
			$display("crc_checked_command_frame_receiver: match");
		end else begin
			$display("crc_checked_command_frame_receiver: mismatch");
		end
		$finish;
	end

endmodule
